// File: rtl/core/mss_pkg.sv
// Shared constants, payload types and control bundles of the message segmentation scheduler.
`timescale 1ns / 1ps

package mss_pkg;

    localparam int RING_SLOTS    = 16;
    localparam int PAYLOAD_BYTES = 1024;
    localparam int MAX_SLICES    = 32;

    localparam int SLOT_W   = $clog2(RING_SLOTS);
    localparam int LEN_W    = 16;
    localparam int ID_W     = 32;
    localparam int IP_W     = 32;
    localparam int PORT_W   = 16;
    localparam int MASK_W   = 32;
    localparam int SERIAL_W = 5;
    localparam int TOTAL_W  = 6;
    localparam int BYTES_W  = 11;
    localparam int OFFSET_W = 15;

    // Internal arithmetic widths
    localparam int PAY_W  = $clog2(PAYLOAD_BYTES + 1);
    localparam int OFFS_W = SERIAL_W + PAY_W;
    localparam int CMP_W  = LEN_W + PAY_W;

    // Reciprocal of the slice payload for the slice count division
    localparam int          RECIP_SHIFT = 32;
    localparam int          RECIP_W     = 32;
    localparam logic [RECIP_W-1:0] RECIP =
        RECIP_W'((64'd1 << RECIP_SHIFT) / PAYLOAD_BYTES);

    localparam logic [ID_W-1:0] CTR_LAST = 32'hffff_ffff;

    localparam logic ACT_SUBMIT = 1'b0;
    localparam logic ACT_TICK   = 1'b1;

    typedef struct packed {
        logic              action;
        logic [LEN_W-1:0]  message_bytes;
        logic [IP_W-1:0]   dest_ip;
        logic [PORT_W-1:0] dest_port;
    } mss_item_t;

    typedef struct packed {
        logic [ID_W-1:0]     message_id;
        logic [SERIAL_W-1:0] slice_serial;
        logic [TOTAL_W-1:0]  slice_total;
        logic [BYTES_W-1:0]  slice_bytes;
        logic [OFFSET_W-1:0] byte_offset;
        logic [IP_W-1:0]     out_ip;
        logic [PORT_W-1:0]   out_port;
    } mss_slice_t;

    typedef struct packed {
        logic load;
        logic div_mul;
        logic div_fix;
        logic commit;
        logic pick;
        logic find;
        logic offs;
        logic emit;
    } mss_cmd_t;

    typedef struct packed {
        logic hit;
        logic out_free;
    } mss_sts_t;

endpackage

// File: rtl/core/mss_if.sv
// Valid/ready channel interfaces for submit/tick items and slice headers.
`timescale 1ns / 1ps

interface mss_item_if
    import mss_pkg::*;
();
    logic      valid;
    logic      ready;
    mss_item_t data;

    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface

interface mss_slice_if
    import mss_pkg::*;
();
    logic       valid;
    logic       ready;
    mss_slice_t data;

    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface

// File: rtl/core/mss_ctrl.sv
// Sequencing state machine of the message segmentation scheduler.
`timescale 1ns / 1ps

module mss_ctrl
    import mss_pkg::*;
(
    input  logic     clk,
    input  logic     rst_n,
    input  logic     item_valid,
    input  logic     item_action,
    output logic     item_ready,
    input  mss_sts_t sts,
    output mss_cmd_t cmd
);

    typedef enum logic [2:0] {
        S_IDLE,
        S_DIV_MUL,
        S_DIV_FIX,
        S_SUBMIT,
        S_PICK,
        S_FIND,
        S_OFFS,
        S_EMIT
    } state_t;

    state_t state_reg;
    state_t state_next;

    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        item_ready = 1'b0;
        case (state_reg)
            S_IDLE:
            begin
                item_ready = 1'b1;
                if (item_valid)
                begin
                    cmd.load   = 1'b1;
                    state_next = (item_action == ACT_TICK) ? S_PICK : S_DIV_MUL;
                end
            end
            S_DIV_MUL:
            begin
                cmd.div_mul = 1'b1;
                state_next  = S_DIV_FIX;
            end
            S_DIV_FIX:
            begin
                cmd.div_fix = 1'b1;
                state_next  = S_SUBMIT;
            end
            S_SUBMIT:
            begin
                cmd.commit = 1'b1;
                state_next = S_IDLE;
            end
            S_PICK:
            begin
                cmd.pick   = 1'b1;
                state_next = S_FIND;
            end
            S_FIND:
            begin
                cmd.find   = 1'b1;
                state_next = S_OFFS;
            end
            S_OFFS:
            begin
                cmd.offs   = 1'b1;
                state_next = S_EMIT;
            end
            S_EMIT:
            begin
                // idle slot: drop the tick; otherwise hold until the output register frees
                if (!sts.hit)
                begin
                    state_next = S_IDLE;
                end
                else if (sts.out_free)
                begin
                    cmd.emit   = 1'b1;
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

`ifndef ASSERT_OFF
    a_cmd_onehot: assert property (@(posedge clk) disable iff (!rst_n)
        $onehot0(cmd))
        else $error("more than one datapath command at once");

    a_emit_room: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.emit |-> sts.out_free)
        else $error("slice emitted into a full output register");

    a_load_leads: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.load |=> (cmd.div_mul || cmd.pick))
        else $error("accepted item not followed by its first work step");
`endif

endmodule

// File: rtl/core/mss_datapath.sv
// Slot ring storage, slice count division, slice selection and output register.
`timescale 1ns / 1ps

module mss_datapath
    import mss_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  mss_cmd_t   cmd,
    output mss_sts_t   sts,
    input  mss_item_t  item_data,
    input  logic       slice_ready,
    output logic       slice_valid,
    output mss_slice_t slice_data
);

    typedef struct packed {
        logic [TOTAL_W-1:0] total;
        logic [LEN_W-1:0]   length;
        logic [ID_W-1:0]    id;
        logic [IP_W-1:0]    ip;
        logic [PORT_W-1:0]  port;
    } entry_t;

    // Ring storage
    entry_t            entry_mem [RING_SLOTS];
    logic [MASK_W-1:0] pend_mem  [RING_SLOTS];
    logic [RING_SLOTS-1:0] pend_vld_reg;
    logic [RING_SLOTS-1:0] pend_vld_next;

    // Counters
    logic [ID_W-1:0]   next_id_reg;
    logic [ID_W-1:0]   next_id_next;
    logic [SLOT_W-1:0] next_slot_reg;
    logic [SLOT_W-1:0] next_slot_next;
    logic [ID_W-1:0]   send_ptr_reg;
    logic [ID_W-1:0]   send_ptr_next;
    logic [SLOT_W-1:0] send_slot_reg;
    logic [SLOT_W-1:0] send_slot_next;

    // Item and working registers
    logic [LEN_W-1:0]  len_reg;
    logic [IP_W-1:0]   ip_reg;
    logic [PORT_W-1:0] port_reg;
    logic [LEN_W-1:0]  quot_reg;
    logic [LEN_W-1:0]  qp_reg;
    entry_t            rd_entry_reg;
    logic [MASK_W-1:0] pmask_rd_reg;
    logic              vld_rd_reg;
    logic              hit_reg;
    logic [SERIAL_W-1:0] serial_reg;
    logic [MASK_W-1:0] cleared_reg;
    logic [OFFS_W-1:0] offset_reg;

    logic       out_valid_reg;
    logic       out_valid_next;
    mss_slice_t out_data_reg;

    // Combinational signals
    logic [LEN_W-1:0]          len_m1;
    logic [LEN_W+RECIP_W-1:0]  prod;
    logic [LEN_W+PAY_W-1:0]    qp_full;
    logic [LEN_W:0]            rem;
    logic                      fix;
    logic [LEN_W:0]            count_full;
    logic                      accept_len;
    logic                      commit_en;
    logic [MASK_W-1:0]         new_mask;
    logic [MASK_W-1:0]         eff_mask;
    logic [SERIAL_W-1:0]       serial;
    logic [CMP_W-1:0]          len_ext;
    logic [CMP_W-1:0]          off_ext;
    logic [CMP_W-1:0]          left;
    logic [CMP_W-1:0]          bytes;
    logic                      advance;
    entry_t                    new_entry;

    function automatic logic [SLOT_W-1:0] slot_step(input logic [ID_W-1:0] ctr,
                                                    input logic [SLOT_W-1:0] slot);
        logic [SLOT_W-1:0] res;
        // counter wrap lands on slot zero as well
        if ((ctr == CTR_LAST) || (slot == SLOT_W'(RING_SLOTS - 1)))
        begin
            res = '0;
        end
        else
        begin
            res = slot + SLOT_W'(1);
        end
        return res;
    endfunction

    // Slice count: ceil(len / payload) = floor((len - 1) / payload) + 1
    assign len_m1     = len_reg - LEN_W'(1);
    assign prod       = (LEN_W+RECIP_W)'(len_m1) * (LEN_W+RECIP_W)'(RECIP);
    assign qp_full    = (LEN_W+PAY_W)'(quot_reg) * (LEN_W+PAY_W)'(PAYLOAD_BYTES);
    assign rem        = {1'b0, len_m1} - {1'b0, qp_reg};
    assign fix        = (rem >= (LEN_W+1)'(PAYLOAD_BYTES));
    assign count_full = {1'b0, quot_reg} + (LEN_W+1)'(1) + (LEN_W+1)'(fix);
    assign accept_len = (len_reg != '0) && (count_full <= (LEN_W+1)'(MAX_SLICES));
    assign commit_en  = cmd.commit && accept_len;

    always_comb
    begin
        for (int i = 0; i < MASK_W; i++)
        begin
            new_mask[i] = ((LEN_W+1)'(i) < count_full);
        end
    end

    always_comb
    begin
        new_entry.total  = TOTAL_W'(count_full);
        new_entry.length = len_reg;
        new_entry.id     = next_id_reg;
        new_entry.ip     = ip_reg;
        new_entry.port   = port_reg;
    end

    // Lowest pending serial
    assign eff_mask = vld_rd_reg ? pmask_rd_reg : '0;

    always_comb
    begin
        serial = '0;
        for (int i = MASK_W - 1; i >= 0; i--)
        begin
            if (eff_mask[i])
            begin
                serial = SERIAL_W'(i);
            end
        end
    end

    // Slice size: min(payload, remaining length)
    assign len_ext = CMP_W'(rd_entry_reg.length);
    assign off_ext = CMP_W'(offset_reg);
    assign left    = (len_ext > off_ext) ? (len_ext - off_ext) : '0;
    assign bytes   = (left > CMP_W'(PAYLOAD_BYTES)) ? CMP_W'(PAYLOAD_BYTES) : left;

    assign advance = cmd.emit && (cleared_reg == '0);

    always_comb
    begin
        pend_vld_next = pend_vld_reg;
        if (commit_en)
        begin
            pend_vld_next[next_slot_reg] = 1'b1;
        end
    end

    assign next_id_next   = commit_en ? (next_id_reg + ID_W'(1)) : next_id_reg;
    assign next_slot_next = commit_en ? slot_step(next_id_reg, next_slot_reg) : next_slot_reg;
    assign send_ptr_next  = advance ? (send_ptr_reg + ID_W'(1)) : send_ptr_reg;
    assign send_slot_next = advance ? slot_step(send_ptr_reg, send_slot_reg) : send_slot_reg;

    assign out_valid_next = cmd.emit ? 1'b1 : (slice_ready ? 1'b0 : out_valid_reg);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pend_vld_reg  <= '0;
            next_id_reg   <= '0;
            next_slot_reg <= '0;
            send_ptr_reg  <= '0;
            send_slot_reg <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            pend_vld_reg  <= pend_vld_next;
            next_id_reg   <= next_id_next;
            next_slot_reg <= next_slot_next;
            send_ptr_reg  <= send_ptr_next;
            send_slot_reg <= send_slot_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            len_reg  <= item_data.message_bytes;
            ip_reg   <= item_data.dest_ip;
            port_reg <= item_data.dest_port;
        end
        if (cmd.div_mul)
        begin
            quot_reg <= prod[RECIP_SHIFT +: LEN_W];
        end
        if (cmd.div_fix)
        begin
            qp_reg <= qp_full[LEN_W-1:0];
        end
        if (cmd.find)
        begin
            hit_reg     <= (eff_mask != '0);
            serial_reg  <= serial;
            cleared_reg <= eff_mask & (eff_mask - MASK_W'(1));
        end
        if (cmd.offs)
        begin
            offset_reg <= OFFS_W'(serial_reg) * OFFS_W'(PAYLOAD_BYTES);
        end
        if (cmd.emit)
        begin
            out_data_reg.message_id   <= rd_entry_reg.id;
            out_data_reg.slice_serial <= serial_reg;
            out_data_reg.slice_total  <= rd_entry_reg.total;
            out_data_reg.slice_bytes  <= BYTES_W'(bytes);
            out_data_reg.byte_offset  <= OFFSET_W'(offset_reg);
            out_data_reg.out_ip       <= rd_entry_reg.ip;
            out_data_reg.out_port     <= rd_entry_reg.port;
        end
    end

    // Slot field memory: written on submit, read on tick
    always_ff @(posedge clk)
    begin
        if (commit_en)
        begin
            entry_mem[next_slot_reg] <= new_entry;
        end
        if (cmd.pick)
        begin
            rd_entry_reg <= entry_mem[send_slot_reg];
        end
    end

    // Pending bitmap memory: one write port shared by submit and emit
    always_ff @(posedge clk)
    begin
        if (commit_en)
        begin
            pend_mem[next_slot_reg] <= new_mask;
        end
        else if (cmd.emit)
        begin
            pend_mem[send_slot_reg] <= cleared_reg;
        end
        if (cmd.pick)
        begin
            pmask_rd_reg <= pend_mem[send_slot_reg];
            vld_rd_reg   <= pend_vld_reg[send_slot_reg];
        end
    end

    assign sts.hit      = hit_reg;
    assign sts.out_free = !out_valid_reg || slice_ready;

    assign slice_valid = out_valid_reg;
    assign slice_data  = out_data_reg;

`ifndef ASSERT_OFF
    a_emit_shows: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.emit |=> slice_valid)
        else $error("emitted slice not presented on the output");

    a_ptr_on_emit: assert property (@(posedge clk) disable iff (!rst_n)
        !$stable(send_ptr_reg) |-> $past(cmd.emit))
        else $error("send pointer moved without an emitted slice");

    a_id_on_commit: assert property (@(posedge clk) disable iff (!rst_n)
        !$stable(next_id_reg) |-> $past(cmd.commit))
        else $error("message identifier moved without a submit");
`endif

endmodule

// File: rtl/core/message_segmentation_scheduler_top.sv
// Top level of the message segmentation scheduler: controller plus datapath.
`timescale 1ns / 1ps

// Usage:
//   item  : valid/ready sink. action 0 submits a message (length, IPv4
//           address, UDP port); action 1 is one send opportunity (tick).
//   slice : valid/ready source of slice headers, one per serving tick.
// A submit stores a pending-slice bitmap and the message fields in the next
// ring slot; zero lengths and lengths above the slice limit are dropped.
// A tick serves the slot at the send pointer: it emits the lowest pending
// slice, clears its bit and advances the pointer once the slot empties.
// One item at a time passes through the state machine.
// A submit runs through transfer, reciprocal multiply, correction and slot
// write. A tick runs through transfer, slot read, priority encode, offset
// multiply and emit; its header is registered into the output register in
// the emit step. The bitmap and slot field memories with a single read and
// write port set this sequence.
// Stall: a header waits in the output register; a later tick stalls in its
// emit step until the register frees, so nothing is lost.
// Reset: asynchronous, active low; clears the pending-valid flag of every slot, the
// identifier counter and the send pointer; slot fields start undefined.
module message_segmentation_scheduler_top
    import mss_pkg::*;
(
    input logic         clk,
    input logic         rst_n,
    mss_item_if.sink    item,
    mss_slice_if.source slice
);

    mss_cmd_t cmd;
    mss_sts_t sts;

    mss_ctrl u_ctrl (
        .clk         (clk),
        .rst_n       (rst_n),
        .item_valid  (item.valid),
        .item_action (item.data.action),
        .item_ready  (item.ready),
        .sts         (sts),
        .cmd         (cmd)
    );

    mss_datapath u_datapath (
        .clk         (clk),
        .rst_n       (rst_n),
        .cmd         (cmd),
        .sts         (sts),
        .item_data   (item.data),
        .slice_ready (slice.ready),
        .slice_valid (slice.valid),
        .slice_data  (slice.data)
    );

endmodule

// File: dv/tb_message_segmentation_scheduler_top.sv
// Testbench for the message segmentation scheduler: slice ledger, item sender and header sink.
`timescale 1ns / 1ps

module tb_message_segmentation_scheduler_top;
    import mss_pkg::*;

    localparam int ITEM_GOAL   = 1700;
    localparam int CYCLE_LIMIT = 300000;
    localparam int HOLD_CYCLES = 400;
    localparam int TAIL_CYCLES = 16;

    // Mirror of the slot ring; owes one header per serving tick.
    class slice_ledger;
        bit [MASK_W-1:0]  pend_bits  [RING_SLOTS];
        bit [TOTAL_W-1:0] slot_total [RING_SLOTS];
        bit [LEN_W-1:0]   slot_len   [RING_SLOTS];
        bit [ID_W-1:0]    slot_id    [RING_SLOTS];
        bit [IP_W-1:0]    slot_ip    [RING_SLOTS];
        bit [PORT_W-1:0]  slot_port  [RING_SLOTS];
        bit [ID_W-1:0]    next_id;
        bit [ID_W-1:0]    send_ptr;
        mss_slice_t       owed_headers [$];
        int               mismatches;

        function new();
            foreach (pend_bits[i])
                pend_bits[i] = '0;
            next_id    = '0;
            send_ptr   = '0;
            mismatches = 0;
        endfunction

        // Returns 1 when the transfer stores a message or yields a header.
        function bit take_item(mss_item_t it);
            int unsigned count;
            int unsigned slot;
            int unsigned serial;
            int unsigned offset;
            int unsigned left;
            int unsigned nbytes;
            mss_slice_t  hdr;
            if (it.action == ACT_SUBMIT)
            begin
                count = (32'(it.message_bytes) + PAYLOAD_BYTES - 1) / PAYLOAD_BYTES;
                // drop empty messages and those needing too many slices
                if (it.message_bytes == 0 || count > MAX_SLICES || count > 32)
                    return 1'b0;
                slot = next_id % RING_SLOTS;
                pend_bits[slot]  = (count >= 32) ? '1 : MASK_W'((64'd1 << count) - 1);
                slot_total[slot] = TOTAL_W'(count);
                slot_len[slot]   = it.message_bytes;
                slot_id[slot]    = next_id;
                slot_ip[slot]    = it.dest_ip;
                slot_port[slot]  = it.dest_port;
                next_id++;
                return 1'b1;
            end
            slot = send_ptr % RING_SLOTS;
            if (pend_bits[slot] == 0)
                return 1'b0;
            serial = 0;
            while (!pend_bits[slot][serial])
                serial++;
            offset = serial * PAYLOAD_BYTES;
            left   = (slot_len[slot] > offset) ? slot_len[slot] - offset : 0;
            nbytes = (left > PAYLOAD_BYTES) ? PAYLOAD_BYTES : left;
            hdr.message_id   = slot_id[slot];
            hdr.slice_serial = SERIAL_W'(serial);
            hdr.slice_total  = slot_total[slot];
            hdr.slice_bytes  = BYTES_W'(nbytes);
            hdr.byte_offset  = OFFSET_W'(offset);
            hdr.out_ip       = slot_ip[slot];
            hdr.out_port     = slot_port[slot];
            owed_headers.push_back(hdr);
            pend_bits[slot][serial] = 1'b0;
            // advance once the slot is drained
            if (pend_bits[slot] == 0)
                send_ptr++;
            return 1'b1;
        endfunction

        task flag(string what);
            $display("mismatch: %s", what);
            mismatches++;
        endtask

        task compare_field(string field, logic [31:0] got, logic [31:0] want);
            if (got !== want)
                flag($sformatf("%s got %0h expected %0h", field, got, want));
        endtask

        task match_header(mss_slice_t got);
            mss_slice_t want;
            if (owed_headers.size() == 0)
            begin
                flag($sformatf("unexpected header for message %0h serial %0d",
                               got.message_id, got.slice_serial));
                return;
            end
            want = owed_headers.pop_front();
            compare_field("message_id", got.message_id, want.message_id);
            compare_field("slice_serial", 32'(got.slice_serial), 32'(want.slice_serial));
            compare_field("slice_total", 32'(got.slice_total), 32'(want.slice_total));
            compare_field("slice_bytes", 32'(got.slice_bytes), 32'(want.slice_bytes));
            compare_field("byte_offset", 32'(got.byte_offset), 32'(want.byte_offset));
            compare_field("out_ip", got.out_ip, want.out_ip);
            compare_field("out_port", 32'(got.out_port), 32'(want.out_port));
        endtask

        task settle();
            if (owed_headers.size() != 0)
                flag($sformatf("%0d slice headers never arrived", owed_headers.size()));
        endtask
    endclass

    logic clk;
    logic rst_n;

    mss_item_if  item_ch ();
    mss_slice_if slice_ch ();

    message_segmentation_scheduler_top u_top (
        .clk   (clk),
        .rst_n (rst_n),
        .item  (item_ch),
        .slice (slice_ch)
    );

    slice_ledger ledger = new();
    bit          calm;
    bit          hold_req;
    int          cycles;

    initial clk = 1'b0;

    always
    begin
        #2 clk = 1'b1;
        #2 clk = 1'b0;
    end

    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_LIMIT)
        begin
            $display("FAILURE");
            $finish;
        end
    end

    always @(posedge clk)
    begin
        if (rst_n && slice_ch.valid && slice_ch.ready)
            ledger.match_header(slice_ch.data);
    end

    // Header sink: random stalls, a quiet stretch, and one long hold-off.
    initial
    begin
        int hold_left;
        hold_left = 0;
        slice_ch.ready <= 1'b0;
        forever
        begin
            @(posedge clk);
            if (hold_req)
            begin
                hold_req  = 1'b0;
                hold_left = HOLD_CYCLES;
            end
            if (hold_left > 0)
            begin
                hold_left--;
                slice_ch.ready <= 1'b0;
            end
            else if (calm)
                slice_ch.ready <= 1'b1;
            else
                slice_ch.ready <= ($urandom_range(0, 99) >= 37);
        end
    end

    // Offer one item, idling at random first; returns at the edge of its transfer.
    task automatic offer(input mss_item_t it);
        while (!calm && $urandom_range(0, 99) < 37)
        begin
            item_ch.valid <= 1'b0;
            @(posedge clk);
        end
        item_ch.valid <= 1'b1;
        item_ch.data  <= it;
        do
        begin
            @(posedge clk);
        end
        while (!item_ch.ready);
        void'(ledger.take_item(it));
    endtask

    function automatic mss_item_t submit_of(bit [LEN_W-1:0] len, bit [IP_W-1:0] ip,
                                            bit [PORT_W-1:0] port);
        mss_item_t it;
        it.action        = ACT_SUBMIT;
        it.message_bytes = len;
        it.dest_ip       = ip;
        it.dest_port     = port;
        return it;
    endfunction

    function automatic mss_item_t tick_item();
        mss_item_t it;
        it.action        = ACT_TICK;
        it.message_bytes = LEN_W'($urandom_range(0, 65535));
        it.dest_ip       = $urandom;
        it.dest_port     = PORT_W'($urandom_range(0, 65535));
        return it;
    endfunction

    // Mostly short messages, some long ones, slice boundaries and the full field range.
    function automatic bit [LEN_W-1:0] pick_length();
        int unsigned r;
        int unsigned k;
        r = $urandom_range(0, 99);
        k = $urandom_range(0, MAX_SLICES + 1);
        if (r < 55)
            return LEN_W'($urandom_range(1, 3 * PAYLOAD_BYTES));
        if (r < 75)
            return LEN_W'($urandom_range(1, MAX_SLICES * PAYLOAD_BYTES));
        if (r < 88)
            return LEN_W'(k * PAYLOAD_BYTES + $urandom_range(0, 2) - 1);
        return LEN_W'($urandom_range(0, 65535));
    endfunction

    initial
    begin
        int submit_pct;
        int sent;
        bit hold_done;
        submit_pct = 40;
        sent       = 0;
        hold_done  = 1'b0;
        rst_n         <= 1'b0;
        item_ch.valid <= 1'b0;
        item_ch.data  <= '0;
        repeat (6) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        offer(tick_item());
        offer(submit_of(LEN_W'(0), 32'h1234_5678, 16'h0101));
        offer(submit_of(LEN_W'(MAX_SLICES * PAYLOAD_BYTES + 1), 32'h0bad_f00d, 16'h7777));
        offer(submit_of(16'hffff, 32'hffff_ffff, 16'hffff));
        offer(submit_of(LEN_W'(1), 32'h0000_0000, 16'h0000));
        offer(tick_item());
        offer(tick_item());
        offer(submit_of(LEN_W'(PAYLOAD_BYTES), 32'hffff_ffff, 16'hffff));
        offer(submit_of(LEN_W'(PAYLOAD_BYTES + 1), 32'h8000_0001, 16'h8001));
        offer(submit_of(LEN_W'(MAX_SLICES * PAYLOAD_BYTES), 32'h5555_aaaa, 16'haa55));
        offer(submit_of(LEN_W'((MAX_SLICES - 1) * PAYLOAD_BYTES + 1), 32'haaaa_5555,
                        16'h55aa));
        repeat (12) offer(tick_item());

        while (sent < ITEM_GOAL)
        begin
            // change the submit/tick balance every so often
            if (sent % 64 == 0)
            begin
                case ($urandom_range(0, 2))
                    0: submit_pct = 15;
                    1: submit_pct = 40;
                    default: submit_pct = 65;
                endcase
            end
            calm = (sent >= 500 && sent < 700);
            if (!hold_done && sent >= 1000)
            begin
                hold_req  = 1'b1;
                hold_done = 1'b1;
            end
            if ($urandom_range(0, 99) < submit_pct)
                offer(submit_of(pick_length(), $urandom, PORT_W'($urandom_range(0, 65535))));
            else
                offer(tick_item());
            sent++;
        end
        item_ch.valid <= 1'b0;
        calm = 1'b0;

        while (ledger.owed_headers.size() != 0)
            @(posedge clk);
        repeat (TAIL_CYCLES) @(posedge clk);
        ledger.settle();
        if (ledger.mismatches == 0)
            $display("SUCCESS");
        else
            $display("FAILURE");
        $finish;
    end

endmodule
